// ----- hdl/qvr_pkg.sv -----
// Shared widths and item types for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

    // Field widths
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;
    localparam int VEC_W     = 16;

    // Internal widths, all exact
    localparam int PROD_FRAC = 2 * QUAT_FRAC;     // fraction bits of q*q and matrix
    localparam int PROD_W    = 2 * QUAT_W;        // q*q product
    localparam int MAT_W     = 2 * QUAT_W + 2;    // 1 - 2a - 2b or 2a +/- 2b
    localparam int TERM_W    = MAT_W + VEC_W;     // matrix entry times vector component
    localparam int ACC_W     = TERM_W + 2;        // sum of three terms plus rounding
    localparam int SHIFT_W   = ACC_W - PROD_FRAC; // integer part of the sum

    localparam logic [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
        logic signed [VEC_W-1:0]  vx;
        logic signed [VEC_W-1:0]  vy;
        logic signed [VEC_W-1:0]  vz;
    } in_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] rx;
        logic signed [VEC_W-1:0] ry;
        logic signed [VEC_W-1:0] rz;
        logic                    clipped;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/quaternion_vector_rotate.sv -----
// Top level: pipelined rotation of a vector by a fixed-point quaternion.
`default_nettype none

// Quaternion vector rotator.
// Input channel (in_valid / in_stall / in_data): one transfer carries a Q2.14
// quaternion (qx, qy, qz, qw) and a signed integer vector (vx, vy, vz).
// Output channel (out_valid / out_stall / out_data): one transfer per input,
// the rotated vector rounded half up and saturated, plus a clipped flag.
// The quaternion is used as given, no normalisation.
// Pipeline: five register stages
//   0: nine quaternion products    1: rotation matrix (doubling, adds)
//   2: nine matrix x vector terms  3: row sums plus rounding half
//   4: round/saturate into the output register
// An item passes the stage registers in order (products, matrix, terms, sums,
// output) before out_valid shows it; throughput is one transfer per cycle
// while out_stall is low, set by one multiplier per product in stages 0 and 2.
// A stage takes new data when it is empty or its contents move on, so
// bubbles are squeezed out and a stalled receiver holds the output register
// while up to four more items fill the earlier stages; in_stall rises only
// when every stage is full and out_stall is high.
// Reset empties all stages; the payload registers are not reset.
module quaternion_vector_rotate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qvr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output qvr_pkg::out_item_t out_data
);
    import qvr_pkg::*;

    localparam int STAGES = 5;

    // product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_XW = 5;
    localparam int P_YZ = 6;
    localparam int P_YW = 7;
    localparam int P_ZW = 8;

    localparam logic signed [MAT_W-1:0] MAT_ONE =
        {{(MAT_W-PROD_FRAC-1){1'b0}}, 1'b1, {PROD_FRAC{1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-PROD_FRAC){1'b0}}, 1'b1, {(PROD_FRAC-1){1'b0}}};

    // 2*p, sign extended to matrix width
    function automatic logic signed [MAT_W-1:0] dbl(input logic signed [PROD_W-1:0] p);
        dbl = {{(MAT_W-PROD_W-1){p[PROD_W-1]}}, p, 1'b0};
    endfunction

    // stage occupancy and advance
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] adv;

    // stage 0
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [VEC_W-1:0]  v0_reg [3];
    logic signed [VEC_W-1:0]  v0_next [3];
    // stage 1
    logic signed [MAT_W-1:0]  mat_reg [9];
    logic signed [MAT_W-1:0]  mat_next [9];
    logic signed [VEC_W-1:0]  v1_reg [3];
    // stage 2
    logic signed [TERM_W-1:0] term_reg [9];
    logic signed [TERM_W-1:0] term_next [9];
    // stage 3
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [ACC_W-1:0]  acc_next [3];
    // stage 4
    out_item_t                out_reg, out_next;

    logic signed [VEC_W-1:0]  rs_val [3];
    logic [2:0]               rs_clip;

    // ---------------- handshake ----------------
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 0: quaternion products ----------------
    always_comb
    begin
        prod_next[P_XX] = PROD_W'(in_data.qx) * PROD_W'(in_data.qx);
        prod_next[P_YY] = PROD_W'(in_data.qy) * PROD_W'(in_data.qy);
        prod_next[P_ZZ] = PROD_W'(in_data.qz) * PROD_W'(in_data.qz);
        prod_next[P_XY] = PROD_W'(in_data.qx) * PROD_W'(in_data.qy);
        prod_next[P_XZ] = PROD_W'(in_data.qx) * PROD_W'(in_data.qz);
        prod_next[P_XW] = PROD_W'(in_data.qx) * PROD_W'(in_data.qw);
        prod_next[P_YZ] = PROD_W'(in_data.qy) * PROD_W'(in_data.qz);
        prod_next[P_YW] = PROD_W'(in_data.qy) * PROD_W'(in_data.qw);
        prod_next[P_ZW] = PROD_W'(in_data.qz) * PROD_W'(in_data.qw);
        v0_next[0]      = in_data.vx;
        v0_next[1]      = in_data.vy;
        v0_next[2]      = in_data.vz;
    end

    // ---------------- stage 1: rotation matrix ----------------
    always_comb
    begin
        mat_next[0] = MAT_ONE - dbl(prod_reg[P_YY]) - dbl(prod_reg[P_ZZ]);
        mat_next[1] = dbl(prod_reg[P_XY]) - dbl(prod_reg[P_ZW]);
        mat_next[2] = dbl(prod_reg[P_XZ]) + dbl(prod_reg[P_YW]);
        mat_next[3] = dbl(prod_reg[P_XY]) + dbl(prod_reg[P_ZW]);
        mat_next[4] = MAT_ONE - dbl(prod_reg[P_XX]) - dbl(prod_reg[P_ZZ]);
        mat_next[5] = dbl(prod_reg[P_YZ]) - dbl(prod_reg[P_XW]);
        mat_next[6] = dbl(prod_reg[P_XZ]) - dbl(prod_reg[P_YW]);
        mat_next[7] = dbl(prod_reg[P_YZ]) + dbl(prod_reg[P_XW]);
        mat_next[8] = MAT_ONE - dbl(prod_reg[P_XX]) - dbl(prod_reg[P_YY]);
    end

    // ---------------- stage 2: matrix x vector terms ----------------
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                term_next[r*3+c] = TERM_W'(mat_reg[r*3+c]) * TERM_W'(v1_reg[c]);
            end
        end
    end

    // ---------------- stage 3: row sums ----------------
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(term_reg[r*3]) + ACC_W'(term_reg[r*3+1])
                        + ACC_W'(term_reg[r*3+2]) + RND_HALF;
        end
    end

    // ---------------- stage 4: round and saturate ----------------
    for (genvar r = 0; r < 3; r++)
    begin : g_rsat
        qvr_round_sat u_rsat (
            .acc  (acc_reg[r]),
            .res  (rs_val[r]),
            .clip (rs_clip[r])
        );
    end

    always_comb
    begin
        out_next.rx      = rs_val[0];
        out_next.ry      = rs_val[1];
        out_next.rz      = rs_val[2];
        out_next.clipped = |rs_clip;
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            prod_reg <= prod_next;
            v0_reg   <= v0_next;
        end
        if (adv[1] && vld_reg[0])
        begin
            mat_reg <= mat_next;
            v1_reg  <= v0_reg;
        end
        if (adv[2] && vld_reg[1])
        begin
            term_reg <= term_next;
        end
        if (adv[3] && vld_reg[2])
        begin
            acc_reg <= acc_next;
        end
        if (adv[4] && vld_reg[3])
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/qvr_round_sat.sv -----
// Drops the fraction of one dot product and saturates it to the vector range.
`default_nettype none

module qvr_round_sat (
    input  logic signed [qvr_pkg::ACC_W-1:0] acc,
    output logic signed [qvr_pkg::VEC_W-1:0] res,
    output logic                             clip
);
    import qvr_pkg::*;

    logic signed [SHIFT_W-1:0]   int_part;
    logic        [SHIFT_W-VEC_W:0] top_bits;

    // acc already carries the half LSB, so truncation rounds half up
    assign int_part = acc[ACC_W-1:PROD_FRAC];
    assign top_bits = int_part[SHIFT_W-1:VEC_W-1];
    assign clip     = !((&top_bits) || !(|top_bits));

    always_comb
    begin
        if (clip)
        begin
            res = int_part[SHIFT_W-1] ? VEC_MIN : VEC_MAX;
        end
        else
        begin
            res = int_part[VEC_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_quaternion_vector_rotate.sv -----
// Testbench for quaternion_vector_rotate: self-checking against an in-bench rotation predictor.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;

    import qvr_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_TAIL   = 200;   // last items run with no idling either side
    localparam int MODE_SPAN    = 128;   // items between changes of idling mode
    localparam int HUSH_SPAN    = 400;   // items between full drains of the pipeline
    localparam int SETTLE_TICKS = 10;    // pipeline is five deep; allow a margin
    localparam int STUCK_LIMIT  = 2000;  // cycles with no transfer on either side

    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [VEC_W-1:0]  vec_t;

    // Keeps the rotations still owed by the block, oldest first, and
    // compares each output transfer against the head of that queue.
    class rotation_scoreboard;
        out_item_t   expected_rotations[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // Exact fixed-point rotation: matrix entries carry 2*QUAT_FRAC
        // fraction bits, each row sum is exact in 64 bits, then rounded
        // half up and saturated to the vector width.
        static function out_item_t rotate_by_quaternion(in_item_t item);
            longint    x, y, z, w;
            longint    v[3];
            longint    unity, half, hi, lo, acc, r;
            longint    xx2, yy2, zz2, xy2, xz2, xw2, yz2, yw2, zw2;
            longint    mat[3][3];
            vec_t      comp[3];
            out_item_t res;

            x     = longint'(item.qx);
            y     = longint'(item.qy);
            z     = longint'(item.qz);
            w     = longint'(item.qw);
            v[0]  = longint'(item.vx);
            v[1]  = longint'(item.vy);
            v[2]  = longint'(item.vz);
            unity = longint'(1) << PROD_FRAC;
            half  = longint'(1) << (PROD_FRAC - 1);
            hi    = longint'(vec_t'(VEC_MAX));
            lo    = longint'(vec_t'(VEC_MIN));

            xx2 = 2 * x * x;  yy2 = 2 * y * y;  zz2 = 2 * z * z;
            xy2 = 2 * x * y;  xz2 = 2 * x * z;  xw2 = 2 * x * w;
            yz2 = 2 * y * z;  yw2 = 2 * y * w;  zw2 = 2 * z * w;

            mat[0][0] = unity - yy2 - zz2; mat[0][1] = xy2 - zw2; mat[0][2] = xz2 + yw2;
            mat[1][0] = xy2 + zw2; mat[1][1] = unity - xx2 - zz2; mat[1][2] = yz2 - xw2;
            mat[2][0] = xz2 - yw2; mat[2][1] = yz2 + xw2; mat[2][2] = unity - xx2 - yy2;

            res.clipped = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc = mat[i][0] * v[0] + mat[i][1] * v[1] + mat[i][2] * v[2];
                r   = (acc + half) >>> PROD_FRAC;
                if (r > hi)
                begin
                    r           = hi;
                    res.clipped = 1'b1;
                end
                if (r < lo)
                begin
                    r           = lo;
                    res.clipped = 1'b1;
                end
                comp[i] = vec_t'(r);
            end
            res.rx = comp[0];
            res.ry = comp[1];
            res.rz = comp[2];
            return res;
        endfunction

        function void note_transfer(in_item_t item);
            expected_rotations.push_back(rotate_by_quaternion(item));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_rotations.size() == 0)
            begin
                $error("unexpected output transfer: rx %0d ry %0d rz %0d clipped %0b",
                       got.rx, got.ry, got.rz, got.clipped);
                failures++;
                return;
            end
            want = expected_rotations.pop_front();
            if (got.rx !== want.rx)
            begin
                $error("rx: expected %0d, got %0d", want.rx, got.rx);
                failures++;
            end
            if (got.ry !== want.ry)
            begin
                $error("ry: expected %0d, got %0d", want.ry, got.ry);
                failures++;
            end
            if (got.rz !== want.rz)
            begin
                $error("rz: expected %0d, got %0d", want.rz, got.rz);
                failures++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_rotations.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;

    bit          tx_idle_on  = 1'b1;  // sender may insert gaps
    bit          rx_idle_on  = 1'b1;  // receiver may stall
    int unsigned stall_left  = 0;
    int unsigned quiet_ticks = 0;

    rotation_scoreboard book = new();

    quaternion_vector_rotate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure: occasional bursts of stalled cycles of random length.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (rx_idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Output monitor. Values read here are those held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(out_data);
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_ticks <= 0;
        end
        else if (quiet_ticks + 1 >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_ticks <= quiet_ticks + 1;
        end
    end

    function automatic in_item_t make_item(int qx, int qy, int qz, int qw,
                                           int vx, int vy, int vz);
        in_item_t item;
        item.qx = quat_t'(qx);
        item.qy = quat_t'(qy);
        item.qz = quat_t'(qz);
        item.qw = quat_t'(qw);
        item.vx = vec_t'(vx);
        item.vy = vec_t'(vy);
        item.vz = vec_t'(vz);
        return item;
    endfunction

    // Range ends, zero, +/-1, +/-unit, or anything.
    function automatic int boundary_value(int unit);
        unique case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return unit;
            4:       return -unit;
            5:       return 1;
            6:       return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Mostly near-unit quaternions (real rotations, little clipping), with
    // raw full-range items and boundary-heavy items mixed in.
    function automatic in_item_t random_rotation();
        in_item_t    item;
        int unsigned pick;
        real         a, b, c, d, norm, scale;

        pick    = $urandom_range(0, 9);
        item.qx = quat_t'($urandom());
        item.qy = quat_t'($urandom());
        item.qz = quat_t'($urandom());
        item.qw = quat_t'($urandom());
        item.vx = vec_t'($urandom());
        item.vy = vec_t'($urandom());
        item.vz = vec_t'($urandom());

        if (pick < 5 || pick == 9)
        begin
            a    = real'(item.qx);
            b    = real'(item.qy);
            c    = real'(item.qz);
            d    = real'(item.qw);
            norm = $sqrt(a * a + b * b + c * c + d * d);
            if (norm >= 1.0)
            begin
                // slightly off unit length so rounding and scaling both show
                scale   = 15800.0 + real'($urandom_range(0, 1168));
                item.qx = quat_t'($rtoi(a * scale / norm));
                item.qy = quat_t'($rtoi(b * scale / norm));
                item.qz = quat_t'($rtoi(c * scale / norm));
                item.qw = quat_t'($rtoi(d * scale / norm));
            end
            if (pick < 5 && $urandom_range(0, 1) == 0)
            begin
                item.vx = vec_t'(int'($urandom_range(0, 4000)) - 2000);
                item.vy = vec_t'(int'($urandom_range(0, 4000)) - 2000);
                item.vz = vec_t'(int'($urandom_range(0, 4000)) - 2000);
            end
        end

        if (pick >= 7 && pick <= 8)
        begin
            item.qx = quat_t'(boundary_value(16384));
            item.qy = quat_t'(boundary_value(16384));
            item.qz = quat_t'(boundary_value(16384));
            item.qw = quat_t'(boundary_value(16384));
        end

        if (pick >= 7)
        begin
            item.vx = vec_t'(boundary_value(1));
            item.vy = vec_t'(boundary_value(1));
            item.vz = vec_t'(boundary_value(1));
        end
        return item;
    endfunction

    // One input transfer. Valid stays high from one item to the next unless
    // a gap is taken; the payload is held while stalled.
    task automatic send_rotation(input in_item_t item);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap      = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        book.note_transfer(item);
    endtask

    // Sender holds off until every owed rotation has come out.
    // The wait is a do-while on the clock edge, so valid is never
    // dropped and raised in the same step.
    task automatic drain_rotations();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.outstanding() != 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, zero and non-unit quaternions, quarter and
        // half turns, range extremes that must clip both ways, and exact
        // halves that must round upwards on both signs.
        send_rotation(make_item(0, 0, 0, 16384, 32767, -32768, 1));
        send_rotation(make_item(0, 0, 0, 0, -32768, -32768, -32768));
        send_rotation(make_item(0, 0, 11585, 11585, 1000, -2000, 300));
        send_rotation(make_item(16384, 0, 0, 0, 100, 200, -300));
        send_rotation(make_item(0, -16384, 0, 0, 32767, 32767, -32768));
        send_rotation(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_rotation(make_item(-32768, -32768, -32768, -32768, -32768, 32767, -32768));
        send_rotation(make_item(0, 0, 8192, 0, 1, -1, 5));     // +0.5 and -0.5
        send_rotation(make_item(0, 0, 8192, 0, 3, -3, -7));    // +1.5 and -1.5
        send_rotation(make_item(8192, 0, 0, 0, -5, 7, -1));
        send_rotation(make_item(16384, 16384, 0, 0, 1234, -4321, 77));
        send_rotation(make_item(32767, 0, 0, -32768, 0, 32767, -1));
        send_rotation(make_item(-1, -1, -1, -1, -1, -1, -1));
        send_rotation(make_item(-16384, 0, 0, 0, 0, 0, 0));
        send_rotation(make_item(-32768, 0, 0, 32767, -32768, 0, 32767));

        drain_rotations();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            else if (n < RANDOM_ITEMS - QUIET_TAIL && n % MODE_SPAN == 0)
            begin
                // any of: both idle, one side idle, neither
                tx_idle_on = $urandom_range(0, 1);
                rx_idle_on <= $urandom_range(0, 1);
            end
            if (n < RANDOM_ITEMS - QUIET_TAIL && n % HUSH_SPAN == HUSH_SPAN / 2)
                drain_rotations();
            send_rotation(random_rotation());
        end

        drain_rotations();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (book.failures == 0 && book.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- quaternion_vector_rotate.f -----
hdl/qvr_pkg.sv
hdl/qvr_round_sat.sv
hdl/quaternion_vector_rotate.sv
test/tb_quaternion_vector_rotate.sv
